### src/dcm_pkg.sv
// shared types, constants and micro-op tables for the attitude matrix integrator
`timescale 1ns / 1ps

package dcm_pkg;

    localparam int DCM_FRAC_BITS = 30;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } dcm_in_t;

    typedef struct packed {
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m13;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic signed [31:0] m23;
        logic signed [31:0] m31;
        logic signed [31:0] m32;
        logic signed [31:0] m33;
    } dcm_out_t;

    typedef logic [4:0] dcm_src_t;

    // register file map
    localparam dcm_src_t SRC_M0   = 5'd0;
    localparam dcm_src_t SRC_M1   = 5'd1;
    localparam dcm_src_t SRC_M2   = 5'd2;
    localparam dcm_src_t SRC_M3   = 5'd3;
    localparam dcm_src_t SRC_M4   = 5'd4;
    localparam dcm_src_t SRC_M5   = 5'd5;
    localparam dcm_src_t SRC_M6   = 5'd6;
    localparam dcm_src_t SRC_M7   = 5'd7;
    localparam dcm_src_t SRC_M8   = 5'd8;
    localparam dcm_src_t SRC_A0   = 5'd9;
    localparam dcm_src_t SRC_A1   = 5'd10;
    localparam dcm_src_t SRC_A2   = 5'd11;
    localparam dcm_src_t SRC_B0   = 5'd12;
    localparam dcm_src_t SRC_B1   = 5'd13;
    localparam dcm_src_t SRC_B2   = 5'd14;
    localparam dcm_src_t SRC_ERR  = 5'd15;
    localparam dcm_src_t SRC_GX   = 5'd16;
    localparam dcm_src_t SRC_GY   = 5'd17;
    localparam dcm_src_t SRC_GZ   = 5'd18;
    localparam dcm_src_t SRC_ZERO = 5'd19;

    localparam int MAT_N = 9;
    localparam logic [1:0] LAST_ROW = 2'd2;

    // micro-op kinds
    localparam logic [3:0] UOP_LOAD  = 4'd0;
    localparam logic [3:0] UOP_MAC   = 4'd1;
    localparam logic [3:0] UOP_MSB   = 4'd2;
    localparam logic [3:0] UOP_WR    = 4'd3;
    localparam logic [3:0] UOP_WRH   = 4'd4;
    localparam logic [3:0] UOP_COPY  = 4'd5;
    localparam logic [3:0] UOP_SQCLR = 4'd6;
    localparam logic [3:0] UOP_SQ    = 4'd7;
    localparam logic [3:0] UOP_SQRT  = 4'd8;
    localparam logic [3:0] UOP_DIV   = 4'd9;
    localparam logic [3:0] UOP_END   = 4'd10;

    typedef struct packed {
        logic [3:0] kind;
        dcm_src_t   src_a;
        dcm_src_t   src_b;
        dcm_src_t   dst;
    } dcm_uop_t;

    typedef struct packed {
        dcm_uop_t uop;
        logic     load_in;
        logic     rd;
        logic     ex;
        logic     acc;
        logic     div_wr;
        logic     publish;
    } dcm_cmd_t;

    typedef struct packed {
        logic sqrt_done;
        logic div_done;
    } dcm_stat_t;

    function automatic dcm_uop_t mk(input logic [3:0] k, input dcm_src_t a,
                                    input dcm_src_t b, input dcm_src_t d);
        dcm_uop_t u;
        u.kind  = k;
        u.src_a = a;
        u.src_b = b;
        u.dst   = d;
        return u;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    // rotation of one row, base element of the row picked by row
    function automatic dcm_uop_t rot_uop(input logic [1:0] row, input logic [3:0] step);
        dcm_src_t a;
        dcm_src_t b;
        dcm_src_t c;
        dcm_uop_t u;
        a = dcm_src_t'({row, 1'b0}) + dcm_src_t'(row);
        b = a + 5'd1;
        c = a + 5'd2;
        case (step)
            4'd0:    u = mk(UOP_LOAD, a, SRC_ZERO, SRC_ZERO);
            4'd1:    u = mk(UOP_MAC, b, SRC_GZ, SRC_ZERO);
            4'd2:    u = mk(UOP_MSB, c, SRC_GY, SRC_ZERO);
            4'd3:    u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_A0);
            4'd4:    u = mk(UOP_LOAD, b, SRC_ZERO, SRC_ZERO);
            4'd5:    u = mk(UOP_MSB, a, SRC_GZ, SRC_ZERO);
            4'd6:    u = mk(UOP_MAC, c, SRC_GX, SRC_ZERO);
            4'd7:    u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_A1);
            4'd8:    u = mk(UOP_LOAD, c, SRC_ZERO, SRC_ZERO);
            4'd9:    u = mk(UOP_MAC, a, SRC_GY, SRC_ZERO);
            4'd10:   u = mk(UOP_MSB, b, SRC_GX, SRC_ZERO);
            4'd11:   u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_A2);
            4'd12:   u = mk(UOP_COPY, SRC_A0, SRC_ZERO, a);
            4'd13:   u = mk(UOP_COPY, SRC_A1, SRC_ZERO, b);
            4'd14:   u = mk(UOP_COPY, SRC_A2, SRC_ZERO, c);
            default: u = mk(UOP_END, SRC_ZERO, SRC_ZERO, SRC_ZERO);
        endcase
        return u;
    endfunction

    function automatic dcm_uop_t ren_uop(input logic [5:0] pc);
        dcm_uop_t u;
        case (pc)
            6'd0:    u = mk(UOP_LOAD, SRC_ZERO, SRC_ZERO, SRC_ZERO);
            6'd1:    u = mk(UOP_MAC, SRC_M0, SRC_M3, SRC_ZERO);
            6'd2:    u = mk(UOP_MAC, SRC_M1, SRC_M4, SRC_ZERO);
            6'd3:    u = mk(UOP_MAC, SRC_M2, SRC_M5, SRC_ZERO);
            6'd4:    u = mk(UOP_WRH, SRC_ZERO, SRC_ZERO, SRC_ERR);
            6'd5:    u = mk(UOP_LOAD, SRC_M0, SRC_ZERO, SRC_ZERO);
            6'd6:    u = mk(UOP_MSB, SRC_ERR, SRC_M3, SRC_ZERO);
            6'd7:    u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_A0);
            6'd8:    u = mk(UOP_LOAD, SRC_M3, SRC_ZERO, SRC_ZERO);
            6'd9:    u = mk(UOP_MSB, SRC_ERR, SRC_M0, SRC_ZERO);
            6'd10:   u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_B0);
            6'd11:   u = mk(UOP_LOAD, SRC_M1, SRC_ZERO, SRC_ZERO);
            6'd12:   u = mk(UOP_MSB, SRC_ERR, SRC_M4, SRC_ZERO);
            6'd13:   u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_A1);
            6'd14:   u = mk(UOP_LOAD, SRC_M4, SRC_ZERO, SRC_ZERO);
            6'd15:   u = mk(UOP_MSB, SRC_ERR, SRC_M1, SRC_ZERO);
            6'd16:   u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_B1);
            6'd17:   u = mk(UOP_LOAD, SRC_M2, SRC_ZERO, SRC_ZERO);
            6'd18:   u = mk(UOP_MSB, SRC_ERR, SRC_M5, SRC_ZERO);
            6'd19:   u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_A2);
            6'd20:   u = mk(UOP_LOAD, SRC_M5, SRC_ZERO, SRC_ZERO);
            6'd21:   u = mk(UOP_MSB, SRC_ERR, SRC_M2, SRC_ZERO);
            6'd22:   u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_B2);
            6'd23:   u = mk(UOP_SQCLR, SRC_ZERO, SRC_ZERO, SRC_ZERO);
            6'd24:   u = mk(UOP_SQ, SRC_A0, SRC_A0, SRC_ZERO);
            6'd25:   u = mk(UOP_SQ, SRC_A1, SRC_A1, SRC_ZERO);
            6'd26:   u = mk(UOP_SQ, SRC_A2, SRC_A2, SRC_ZERO);
            6'd27:   u = mk(UOP_SQRT, SRC_ZERO, SRC_ZERO, SRC_ZERO);
            6'd28:   u = mk(UOP_DIV, SRC_A0, SRC_ZERO, SRC_A0);
            6'd29:   u = mk(UOP_DIV, SRC_A1, SRC_ZERO, SRC_A1);
            6'd30:   u = mk(UOP_DIV, SRC_A2, SRC_ZERO, SRC_A2);
            6'd31:   u = mk(UOP_SQCLR, SRC_ZERO, SRC_ZERO, SRC_ZERO);
            6'd32:   u = mk(UOP_SQ, SRC_B0, SRC_B0, SRC_ZERO);
            6'd33:   u = mk(UOP_SQ, SRC_B1, SRC_B1, SRC_ZERO);
            6'd34:   u = mk(UOP_SQ, SRC_B2, SRC_B2, SRC_ZERO);
            6'd35:   u = mk(UOP_SQRT, SRC_ZERO, SRC_ZERO, SRC_ZERO);
            6'd36:   u = mk(UOP_DIV, SRC_B0, SRC_ZERO, SRC_B0);
            6'd37:   u = mk(UOP_DIV, SRC_B1, SRC_ZERO, SRC_B1);
            6'd38:   u = mk(UOP_DIV, SRC_B2, SRC_ZERO, SRC_B2);
            6'd39:   u = mk(UOP_LOAD, SRC_ZERO, SRC_ZERO, SRC_ZERO);
            6'd40:   u = mk(UOP_MAC, SRC_A1, SRC_B2, SRC_ZERO);
            6'd41:   u = mk(UOP_MSB, SRC_A2, SRC_B1, SRC_ZERO);
            6'd42:   u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_M6);
            6'd43:   u = mk(UOP_LOAD, SRC_ZERO, SRC_ZERO, SRC_ZERO);
            6'd44:   u = mk(UOP_MAC, SRC_A2, SRC_B0, SRC_ZERO);
            6'd45:   u = mk(UOP_MSB, SRC_A0, SRC_B2, SRC_ZERO);
            6'd46:   u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_M7);
            6'd47:   u = mk(UOP_LOAD, SRC_ZERO, SRC_ZERO, SRC_ZERO);
            6'd48:   u = mk(UOP_MAC, SRC_A0, SRC_B1, SRC_ZERO);
            6'd49:   u = mk(UOP_MSB, SRC_A1, SRC_B0, SRC_ZERO);
            6'd50:   u = mk(UOP_WR, SRC_ZERO, SRC_ZERO, SRC_M8);
            6'd51:   u = mk(UOP_COPY, SRC_A0, SRC_ZERO, SRC_M0);
            6'd52:   u = mk(UOP_COPY, SRC_A1, SRC_ZERO, SRC_M1);
            6'd53:   u = mk(UOP_COPY, SRC_A2, SRC_ZERO, SRC_M2);
            6'd54:   u = mk(UOP_COPY, SRC_B0, SRC_ZERO, SRC_M3);
            6'd55:   u = mk(UOP_COPY, SRC_B1, SRC_ZERO, SRC_M4);
            6'd56:   u = mk(UOP_COPY, SRC_B2, SRC_ZERO, SRC_M5);
            default: u = mk(UOP_END, SRC_ZERO, SRC_ZERO, SRC_ZERO);
        endcase
        return u;
    endfunction

endpackage

### src/dcm_attitude_integrator.sv
// top level of the attitude direction cosine matrix integrator
// rotate beat: three rows of shared-multiplier steps from accept to result
// renormalize beat at 30 fraction bits: time set mostly by the bit-serial divider, run once
// per element of two rows, and the square root step, run once per row, twice in all
// one beat at a time, next accept in the cycle after the result loads; it is taken while
// the previous result waits on m_ready. sync active-low reset: identity, no result pending
`timescale 1ns / 1ps

module dcm_attitude_integrator import dcm_pkg::*; #(
    parameter int FRAC_BITS = DCM_FRAC_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dcm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output dcm_out_t m_data
);

    dcm_cmd_t  cmd;
    dcm_stat_t stat;

    dcm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_cmd  (s_data.cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dcm_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_data (s_data),
        .stat    (stat),
        .m_data  (m_data)
    );

endmodule

### src/dcm_sqrt.sv
// bit-pair serial integer square root of a 64-bit sum of squares
`timescale 1ns / 1ps

module dcm_sqrt import dcm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;
    logic        take;

    assign trial = res_reg + bit_reg;
    assign take  = x_reg >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= rad;
            res_reg <= '0;
            bit_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (take) begin
                x_reg   <= x_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

### src/dcm_div.sv
// restoring divider for row normalization, rounded and saturated signed result
`timescale 1ns / 1ps

module dcm_div import dcm_pkg::*; #(
    parameter int FRAC_BITS = DCM_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] value,
    input  logic [31:0]        den,
    output logic               done,
    output logic signed [31:0] quo
);

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] num_reg;
    logic [NUM_W-1:0] q_reg;
    logic [31:0]      rem_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [31:0]      mag;
    logic [32:0]      shifted;
    logic             fits;
    logic [NUM_W-1:0] lim;
    logic [31:0]      qs;

    assign mag     = value[31] ? 32'(-value) : 32'(value);
    assign shifted = {rem_reg, num_reg[NUM_W-1]};
    assign fits    = shifted >= {1'b0, den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= value[31];
            num_reg <= {mag, {FRAC_BITS{1'b0}}} + NUM_W'(den >> 1);
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            num_reg <= num_reg << 1;
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? 32'(shifted - {1'b0, den}) : shifted[31:0];
        end
    end

    assign lim  = NUM_W'(neg_reg ? 32'h8000_0000 : 32'h7fff_ffff);
    assign qs   = (q_reg > lim) ? lim[31:0] : q_reg[31:0];
    assign quo  = neg_reg ? signed'(32'(-qs)) : signed'(qs);
    assign done = done_reg;

endmodule

### src/dcm_datapath.sv
// register file, shared multiplier, accumulator and sqrt/div units
`timescale 1ns / 1ps

module dcm_datapath import dcm_pkg::*; #(
    parameter int FRAC_BITS = DCM_FRAC_BITS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  dcm_cmd_t  cmd,
    input  dcm_in_t   in_data,
    output dcm_stat_t stat,
    output dcm_out_t  m_data
);

    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0] mem [16];
    logic [15:0]        vld_reg;
    logic signed [31:0] mat_reg [MAT_N];
    logic signed [31:0] gx_reg;
    logic signed [31:0] gy_reg;
    logic signed [31:0] gz_reg;
    logic signed [31:0] rd_a_reg;
    logic signed [31:0] rd_b_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic [63:0]        sum_reg;
    dcm_out_t           out_reg;

    logic signed [63:0] rq;
    logic               wr_en;
    logic signed [31:0] wr_data;
    logic               sqrt_done;
    logic [31:0]        root;
    logic               div_done;
    logic signed [31:0] quo;
    logic               sqrt_go;
    logic               div_go;

    function automatic logic signed [31:0] rf_value(input dcm_src_t s);
        logic signed [31:0] v;
        if (s[4]) begin
            case (s)
                SRC_GX:  v = gx_reg;
                SRC_GY:  v = gy_reg;
                SRC_GZ:  v = gz_reg;
                default: v = '0;
            endcase
        end else if (!vld_reg[s[3:0]]) begin
            v = (s == SRC_M0 || s == SRC_M4 || s == SRC_M8) ? ONE : 32'sd0;
        end else begin
            v = mem[s[3:0]];
        end
        return v;
    endfunction

    assign rq      = (prod_reg + RND) >>> FRAC_BITS;
    assign sqrt_go = cmd.ex && (cmd.uop.kind == UOP_SQRT);
    assign div_go  = cmd.ex && (cmd.uop.kind == UOP_DIV);

    always_comb begin
        wr_en   = 1'b0;
        wr_data = rd_a_reg;
        if (cmd.div_wr) begin
            wr_en   = 1'b1;
            wr_data = (root == '0) ? rd_a_reg : quo;
        end else if (cmd.ex) begin
            case (cmd.uop.kind)
                UOP_WR: begin
                    wr_en   = 1'b1;
                    wr_data = sat32(acc_reg);
                end
                UOP_WRH: begin
                    wr_en   = 1'b1;
                    wr_data = sat32(acc_reg >>> 1);
                end
                UOP_COPY: begin
                    wr_en   = 1'b1;
                    wr_data = rd_a_reg;
                end
                default: wr_en = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            for (int k = 0; k < MAT_N; k++) begin
                mat_reg[k] <= (k % 4 == 0) ? ONE : 32'sd0;
            end
        end else if (wr_en && !cmd.uop.dst[4]) begin
            vld_reg[cmd.uop.dst[3:0]] <= 1'b1;
            for (int k = 0; k < MAT_N; k++) begin
                if (cmd.uop.dst == dcm_src_t'(k)) begin
                    mat_reg[k] <= wr_data;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && !cmd.uop.dst[4]) begin
            mem[cmd.uop.dst[3:0]] <= wr_data;
        end
        if (cmd.rd) begin
            rd_a_reg <= rf_value(cmd.uop.src_a);
            rd_b_reg <= rf_value(cmd.uop.src_b);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            gx_reg <= in_data.rate_x;
            gy_reg <= in_data.rate_y;
            gz_reg <= in_data.rate_z;
        end
        if (cmd.ex) begin
            case (cmd.uop.kind)
                UOP_LOAD:  acc_reg  <= 64'(rd_a_reg);
                UOP_SQCLR: sum_reg  <= '0;
                default:   prod_reg <= rd_a_reg * rd_b_reg;
            endcase
        end
        if (cmd.acc) begin
            case (cmd.uop.kind)
                UOP_MAC: acc_reg <= acc_reg + rq;
                UOP_MSB: acc_reg <= acc_reg - rq;
                default: sum_reg <= sum_reg + unsigned'(prod_reg);
            endcase
        end
        if (cmd.publish) begin
            out_reg.m11 <= mat_reg[0];
            out_reg.m12 <= mat_reg[1];
            out_reg.m13 <= mat_reg[2];
            out_reg.m21 <= mat_reg[3];
            out_reg.m22 <= mat_reg[4];
            out_reg.m23 <= mat_reg[5];
            out_reg.m31 <= mat_reg[6];
            out_reg.m32 <= mat_reg[7];
            out_reg.m33 <= mat_reg[8];
        end
    end

    dcm_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_go),
        .rad     (sum_reg),
        .done    (sqrt_done),
        .root    (root)
    );

    dcm_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_go),
        .value   (rd_a_reg),
        .den     (root),
        .done    (div_done),
        .quo     (quo)
    );

    assign stat.sqrt_done = sqrt_done;
    assign stat.div_done  = div_done;
    assign m_data         = out_reg;

endmodule

### src/dcm_ctrl.sv
// sequencer that steps the rotate and renormalize micro-op programs
`timescale 1ns / 1ps

module dcm_ctrl import dcm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      in_cmd,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  dcm_stat_t stat,
    output dcm_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_ACC  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [5:0] pc_reg;
    logic [5:0] pc_next;
    logic [1:0] row_reg;
    logic [1:0] row_next;
    logic       prog_reg;
    logic       prog_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    dcm_uop_t   uop;

    assign uop = prog_reg ? ren_uop(pc_reg) : rot_uop(row_reg, pc_reg[3:0]);

    always_comb begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        row_next    = row_reg;
        prog_next   = prog_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        cmd.uop     = uop;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    prog_next   = in_cmd;
                    pc_next     = '0;
                    row_next    = '0;
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cmd.ex = 1'b1;
                unique case (uop.kind) inside
                    UOP_MAC, UOP_MSB, UOP_SQ: state_next = ST_ACC;
                    UOP_SQRT, UOP_DIV:        state_next = ST_WAIT;
                    UOP_END: begin
                        if (!prog_reg && row_reg != LAST_ROW) begin
                            row_next   = row_reg + 2'd1;
                            pc_next    = '0;
                            state_next = ST_READ;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end
                    default: begin
                        pc_next    = pc_reg + 6'd1;
                        state_next = ST_READ;
                    end
                endcase
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                pc_next    = pc_reg + 6'd1;
                state_next = ST_READ;
            end
            ST_WAIT: begin
                if (uop.kind == UOP_DIV ? stat.div_done : stat.sqrt_done) begin
                    cmd.div_wr = (uop.kind == UOP_DIV);
                    pc_next    = pc_reg + 6'd1;
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.publish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pc_reg      <= '0;
            row_reg     <= '0;
            prog_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pc_reg      <= pc_next;
            row_reg     <= row_next;
            prog_reg    <= prog_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

### src/dcm_checker.sv
// port-level checks for the attitude integrator and their bind
`timescale 1ns / 1ps

module dcm_checker import dcm_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input dcm_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input dcm_out_t m_data
);

    logic [1:0] pend_reg;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_reg + 2'(in_beat) - 2'(out_beat);
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_ready)
        else $error("ready held high right after an input beat");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pend_reg != 2'd0)
        else $error("result beat with no input beat outstanding");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result pending or not ready after reset");

endmodule

bind dcm_attitude_integrator dcm_checker u_dcm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
